[hw/rtl/gpf_pkg.sv]
package gpf_pkg;

  // Grid limits and field widths
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 1024;
  localparam int VALUE_BITS = 16;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  // Window cells behind the incoming column, and candidates judged per word
  localparam int N_CELLS = 2;
  localparam int N_CANDS = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS,
    CFG_COLS
  } cfg_idx_e;

  // One line buffer entry: the two rows above the current one
  typedef struct packed {
    logic [VALUE_BITS-1:0] older;
    logic [VALUE_BITS-1:0] newer;
  } line_t;

  // One window column: two rows up, one row up, current row
  typedef struct packed {
    logic [VALUE_BITS-1:0] older;
    logic [VALUE_BITS-1:0] newer;
    logic [VALUE_BITS-1:0] cur;
  } col_t;

  // A peak candidate or the latched peak
  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cand_t;

  // True if centre beats a neighbor, or the neighbor lies outside the grid
  function automatic logic beats(logic [VALUE_BITS-1:0] centre, logic has_nb,
                                 logic [VALUE_BITS-1:0] nb);
    return !has_nb || (centre > nb);
  endfunction

endpackage

[hw/rtl/gpf_line_buf.sv]
module gpf_line_buf (
  input  logic                    clk_i,
  input  logic                    rd_en_i,
  input  logic [gpf_pkg::COL_W-1:0] rd_addr_i,
  input  logic                    wr_en_i,
  input  logic [gpf_pkg::COL_W-1:0] wr_addr_i,
  input  gpf_pkg::line_t          wr_data_i,
  output gpf_pkg::line_t          rd_data_o
);

  gpf_pkg::line_t mem_q [gpf_pkg::MAX_COLS];
  gpf_pkg::line_t rd_q;

  // Write the updated column
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read with write-first bypass when both hit the same column
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

[hw/rtl/gpf_win_cell.sv]
module gpf_win_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  gpf_pkg::col_t col_i,
  output gpf_pkg::col_t col_o
);

  gpf_pkg::col_t col_q;

  // Take the column from the neighbor on each new word
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

[hw/rtl/gpf_peak_sel.sv]
module gpf_peak_sel (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  logic                                 done_i,
  input  gpf_pkg::cand_t [gpf_pkg::N_CANDS-1:0] cand_i,
  output gpf_pkg::cand_t                       res_o
);

  gpf_pkg::cand_t latch_q;
  gpf_pkg::cand_t latch_d;

  // Fold candidates in raster order; an earlier row always replaces a later one
  always_comb begin
    latch_d = latch_q;
    for (int k = 0; k < gpf_pkg::N_CANDS; k++) begin
      if (cand_i[k].hit && (!latch_d.hit || (cand_i[k].row < latch_d.row))) begin
        latch_d = cand_i[k];
      end
    end
  end

  // Hold the first peak; drop it at grid end or on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
    end else if (clear_i || done_i) begin
      latch_q <= '0;
    end else begin
      latch_q <= latch_d;
    end
  end

  assign res_o = latch_d;

endmodule

[hw/rtl/grid_peak_finder.sv]
// Throughput: one word per cycle, also across grid ends; a word that closes a grid
//   waits only while both result slots (output register and skid register) stay full.
// Result path: the grid's last word enters stage 1 on accept while its line buffer
//   column is read, then the window judge loads the output register, or the skid
//   register while an earlier result is still held.
// Reset: clears counters, peak latch and output valid; grid size returns to 1x1.
//   The line buffers are not cleared and need no clearing pass.
module grid_peak_finder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gpf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gpf_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gpf_pkg::VALUE_BITS-1:0]  cell_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            peak_found_o,
  output logic [gpf_pkg::ROW_W-1:0]       peak_row_o,
  output logic [gpf_pkg::COL_W-1:0]       peak_col_o
);

  localparam int ROW_W = gpf_pkg::ROW_W;
  localparam int COL_W = gpf_pkg::COL_W;
  localparam int CFG_W = gpf_pkg::CFG_W;

  logic [ROW_W-1:0] rows_last_q, rows_last_d;
  logic [COL_W-1:0] cols_last_q, cols_last_d;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             cfg_restart;
  logic             in_acc;
  logic             last_row, last_col, at_last;

  logic                            s1_valid_q;
  logic [ROW_W-1:0]                s1_row_q;
  logic [COL_W-1:0]                s1_col_q;
  logic [gpf_pkg::VALUE_BITS-1:0]  s1_v_q;
  logic                            s1_lrow_q, s1_lcol_q;
  logic                            s1_last;

  gpf_pkg::line_t rd_data;
  gpf_pkg::line_t wr_data;
  gpf_pkg::col_t  win [gpf_pkg::N_CELLS+1];

  logic r_ge1, r_ge2, c_ge1, c_ge2;
  gpf_pkg::cand_t [gpf_pkg::N_CANDS-1:0] cands;
  gpf_pkg::cand_t res;

  logic             out_valid_q;
  logic             out_found_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;

  logic             skid_valid_q;
  logic             skid_found_q;
  logic [ROW_W-1:0] skid_row_q;
  logic [COL_W-1:0] skid_col_q;

  logic             pop;
  logic             out_load, out_from_skid, skid_load;
  logic [1:0]       occ_next;
  logic             new_found;
  logic [ROW_W-1:0] new_row;
  logic [COL_W-1:0] new_col;

  // Map register writes to last row / last column, with zero and saturation
  always_comb begin
    if (cfg_data_i == '0) begin
      rows_last_d = '0;
      cols_last_d = '0;
    end else begin
      rows_last_d = ROW_W'(cfg_data_i - CFG_W'(1));
      cols_last_d = COL_W'(cfg_data_i - CFG_W'(1));
    end
    if (cfg_data_i > CFG_W'(gpf_pkg::MAX_ROWS)) begin
      rows_last_d = ROW_W'(gpf_pkg::MAX_ROWS - 1);
    end
    if (cfg_data_i > CFG_W'(gpf_pkg::MAX_COLS)) begin
      cols_last_d = COL_W'(gpf_pkg::MAX_COLS - 1);
    end
  end

  assign cfg_restart = cfg_we_i &&
                       ((gpf_pkg::cfg_idx_e'(cfg_idx_i) == gpf_pkg::CFG_ROWS) ||
                        (gpf_pkg::cfg_idx_e'(cfg_idx_i) == gpf_pkg::CFG_COLS));

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= '0;
      cols_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (gpf_pkg::cfg_idx_e'(cfg_idx_i))
        gpf_pkg::CFG_ROWS: rows_last_q <= rows_last_d;
        gpf_pkg::CFG_COLS: cols_last_q <= cols_last_d;
        default: ;
      endcase
    end
  end

  // Result slots held after this edge, not counting a word closing a grid now
  assign pop      = out_valid_q && !out_stall_i;
  assign occ_next = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(s1_last) - 2'(pop);

  // Input word acceptance; hold a grid-closing word while both slots stay full
  assign last_row   = (row_q == rows_last_q);
  assign last_col   = (col_q == cols_last_q);
  assign at_last    = last_row && last_col;
  assign s1_last    = s1_valid_q && s1_lrow_q && s1_lcol_q;
  assign in_stall_o = at_last && occ_next[1];
  assign in_acc     = in_valid_i && !in_stall_o;

  // Advance raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_restart) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_v_q    <= cell_value_i;
      s1_lrow_q <= last_row;
      s1_lcol_q <= last_col;
    end
  end

  // Line buffers: read the column on accept, write it back in the following cycle
  assign wr_data = '{older: rd_data.newer, newer: s1_v_q};

  gpf_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // Window: incoming column, then cells holding the columns to its left
  assign win[0] = '{older: rd_data.older, newer: rd_data.newer, cur: s1_v_q};

  for (genvar k = 0; k < gpf_pkg::N_CELLS; k++) begin : g_cell
    gpf_win_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (s1_valid_q),
      .col_i   (win[k]),
      .col_o   (win[k+1])
    );
  end

  // Neighbor existence
  assign r_ge1 = (s1_row_q != '0);
  assign r_ge2 = (s1_row_q > ROW_W'(1));
  assign c_ge1 = (s1_col_q != '0);
  assign c_ge2 = (s1_col_q > COL_W'(1));

  // Candidates in raster order: row above (left column, then this column on
  // the last column), then last row (left column, then this column at grid end)
  always_comb begin
    cands[0].hit = s1_valid_q && r_ge1 && c_ge1 &&
                   gpf_pkg::beats(win[1].newer, r_ge2, win[1].older) &&
                   gpf_pkg::beats(win[1].newer, 1'b1, win[1].cur) &&
                   gpf_pkg::beats(win[1].newer, c_ge2, win[2].newer) &&
                   gpf_pkg::beats(win[1].newer, 1'b1, win[0].newer);
    cands[0].row = s1_row_q - ROW_W'(1);
    cands[0].col = s1_col_q - COL_W'(1);

    cands[1].hit = s1_valid_q && r_ge1 && s1_lcol_q &&
                   gpf_pkg::beats(win[0].newer, r_ge2, win[0].older) &&
                   gpf_pkg::beats(win[0].newer, 1'b1, win[0].cur) &&
                   gpf_pkg::beats(win[0].newer, c_ge1, win[1].newer);
    cands[1].row = s1_row_q - ROW_W'(1);
    cands[1].col = s1_col_q;

    cands[2].hit = s1_valid_q && s1_lrow_q && c_ge1 &&
                   gpf_pkg::beats(win[1].cur, r_ge1, win[1].newer) &&
                   gpf_pkg::beats(win[1].cur, c_ge2, win[2].cur) &&
                   gpf_pkg::beats(win[1].cur, 1'b1, win[0].cur);
    cands[2].row = s1_row_q;
    cands[2].col = s1_col_q - COL_W'(1);

    cands[3].hit = s1_valid_q && s1_lrow_q && s1_lcol_q &&
                   gpf_pkg::beats(win[0].cur, r_ge1, win[0].newer) &&
                   gpf_pkg::beats(win[0].cur, c_ge1, win[1].cur);
    cands[3].row = s1_row_q;
    cands[3].col = s1_col_q;
  end

  gpf_peak_sel u_peak_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_restart),
    .done_i  (s1_last),
    .cand_i  (cands),
    .res_o   (res)
  );

  // Route a new result into the output register, or park it in the skid register
  assign new_found     = res.hit;
  assign new_row       = res.hit ? res.row : '0;
  assign new_col       = res.hit ? res.col : '0;
  assign out_from_skid = pop && skid_valid_q;
  assign out_load      = s1_last && (!out_valid_q || (pop && !skid_valid_q));
  assign skid_load     = s1_last && out_valid_q && (!pop || skid_valid_q);

  // Result slot valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_load || out_from_skid) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (skid_load) begin
        skid_valid_q <= 1'b1;
      end else if (out_from_skid) begin
        skid_valid_q <= 1'b0;
      end
    end
  end

  // Result slot payloads
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= new_found;
      out_row_q   <= new_row;
      out_col_q   <= new_col;
    end else if (out_from_skid) begin
      out_found_q <= skid_found_q;
      out_row_q   <= skid_row_q;
      out_col_q   <= skid_col_q;
    end
    if (skid_load) begin
      skid_found_q <= new_found;
      skid_row_q   <= new_row;
      skid_col_q   <= new_col;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign peak_found_o = out_found_q;
  assign peak_row_o   = out_row_q;
  assign peak_col_o   = out_col_q;

  // A grid-closing word never finds both result slots occupied
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_last |-> !skid_valid_q)
    else $error("result overwrote a pending output word");

  // Raster position wraps to the origin after the last word of a grid
  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && at_last && !cfg_restart |=> (row_q == '0) && (col_q == '0))
    else $error("raster position did not restart after grid end");

  // Column position stays within the configured width
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= cols_last_q)
    else $error("column counter past last column");

  // No peak means zero coordinates
  a_no_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> (out_row_q == '0) && (out_col_q == '0))
    else $error("coordinates set without a peak");

endmodule
